### rtl/rgm_pkg.sv
// ----------------------------------------------------------------------------
// rgm_pkg
// Shared constants, types and helpers of the Rec.2020 to Rec.709 gamut mapper.
// ----------------------------------------------------------------------------
package rgm_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int COEF_FRAC_BITS = 14;

  localparam int IN_W   = 18;
  localparam int OUT_W  = 17;
  localparam int REG_W  = 17;
  localparam int IDX_W  = 2;
  localparam int TDATA_IN_W  = 56;
  localparam int TDATA_OUT_W = 56;

  // Internal value widths, sized from the input range and the matrix gains.
  localparam int CH_W   = 21;
  localparam int LUM_W  = 23;
  localparam int DIFF_W = 24;
  localparam int NUM_W  = 22;
  localparam int AMT_W  = 40;

  localparam int DIV1_NW = NUM_W + FRAC_BITS;
  localparam int DIV1_DW = DIFF_W;
  localparam int DIV2_DW = LUM_W;
  localparam int DIV2_NW = LUM_W + FRAC_BITS;
  localparam int DIV2_QW = OUT_W;

  localparam int ONE = 1 << FRAC_BITS;

  localparam int MAT_X10000 [9] = '{16605, -5876, -728,
                                    -1246, 11329, -84,
                                    -181, -1006, 11187};

  typedef enum logic [IDX_W-1:0] {
    REG_LUMA_RED   = 2'd0,
    REG_LUMA_GREEN = 2'd1,
    REG_LUMA_BLUE  = 2'd2,
    REG_SAT_KEEP   = 2'd3
  } reg_idx_t;

  // Per-pixel values that ride alongside the mix-amount dividers.
  typedef struct packed {
    logic [2:0][CH_W-1:0] ch;
    logic [LUM_W-1:0]     lum;
    logic [2:0]           below;
    logic [2:0]           above;
    logic [2:0]           q_neg;
  } side_t;

  function automatic int coef_of(input int c);
    int mag;
    mag = (c < 0) ? -c : c;
    mag = (mag * (1 << COEF_FRAC_BITS) + 5000) / 10000;
    return (c < 0) ? -mag : mag;
  endfunction

  // Arithmetic right shift with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int s);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    r = (mag + (64'd1 << (s - 1))) >> s;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

### rtl/rgm_dly.sv
// ----------------------------------------------------------------------------
// rgm_dly
// Enabled shift line that keeps side values level with a divider pipeline.
// ----------------------------------------------------------------------------
module rgm_dly #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[N-1];

endmodule

### rtl/rgm_div.sv
// ----------------------------------------------------------------------------
// rgm_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rgm_div #(
  parameter int NW = 38,
  parameter int DW = 24,
  parameter int QW = 38
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // The quotient must fit in QW bits, so the bits above QW start below den.
  logic [DW-1:0] rem  [1:QW];
  logic [QW-1:0] bits [1:QW];
  logic [QW-1:0] qacc [1:QW];
  logic [DW-1:0] dsr  [1:QW];

  logic [DW-1:0] rem0;
  logic [QW-1:0] bits0;

  assign rem0  = DW'(num >> QW);
  assign bits0 = num[QW-1:0];

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [DW-1:0] prev_rem;
    logic [QW-1:0] prev_bits;
    logic [QW-1:0] prev_q;
    logic [DW-1:0] prev_den;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 1) begin : g_first
      assign prev_rem  = rem0;
      assign prev_bits = bits0;
      assign prev_q    = '0;
      assign prev_den  = den;
    end else begin : g_next
      assign prev_rem  = rem[s-1];
      assign prev_bits = bits[s-1];
      assign prev_q    = qacc[s-1];
      assign prev_den  = dsr[s-1];
    end

    assign trial = {prev_rem, prev_bits[QW-1]};
    assign ge    = (trial >= {1'b0, prev_den});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= ge ? DW'(trial - {1'b0, prev_den}) : trial[DW-1:0];
        bits[s] <= prev_bits << 1;
        qacc[s] <= {prev_q[QW-2:0], ge};
        dsr[s]  <= prev_den;
      end
    end
  end

  assign quo = qacc[QW];

endmodule

### rtl/rgm_front.sv
// ----------------------------------------------------------------------------
// rgm_front
// Color matrix, luminance and divider operands for the gray-mix amounts.
// ----------------------------------------------------------------------------
module rgm_front (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic [rgm_pkg::IN_W-1:0]                 in_red,
  input  logic [rgm_pkg::IN_W-1:0]                 in_green,
  input  logic [rgm_pkg::IN_W-1:0]                 in_blue,
  input  logic [rgm_pkg::REG_W-1:0]                w_red,
  input  logic [rgm_pkg::REG_W-1:0]                w_green,
  input  logic [rgm_pkg::REG_W-1:0]                w_blue,
  output rgm_pkg::side_t                           side,
  output logic [2:0][rgm_pkg::DIV1_NW-1:0]         dividend,
  output logic [2:0][rgm_pkg::DIV1_DW-1:0]         divisor
);

  import rgm_pkg::*;

  logic signed [34:0]       prod [3][3];
  logic signed [CH_W-1:0]   ch1  [3];
  logic signed [38:0]       lp   [3];
  logic signed [CH_W-1:0]   ch2  [3];
  logic [IN_W-1:0]          src  [3];
  logic [REG_W-1:0]         wt   [3];

  assign src[0] = in_red;
  assign src[1] = in_green;
  assign src[2] = in_blue;
  assign wt[0]  = w_red;
  assign wt[1]  = w_green;
  assign wt[2]  = w_blue;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam logic signed [16:0] C = 17'(coef_of(MAT_X10000[i*3+j]));
      always_ff @(posedge clk) begin
        if (en) begin
          prod[i][j] <= C * $signed({1'b0, src[j]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ch1[i] <= CH_W'(rshr(64'(prod[i][0]) + 64'(prod[i][1]) + 64'(prod[i][2]),
                             COEF_FRAC_BITS));
        lp[i]  <= $signed({1'b0, wt[i]}) * ch1[i];
        ch2[i] <= ch1[i];
      end
    end
  end

  logic signed [LUM_W-1:0]  lum;
  logic signed [CH_W-1:0]   ch3  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      lum <= LUM_W'(rshr(64'(lp[0]) + 64'(lp[1]) + 64'(lp[2]), 16));
      ch3 <= ch2;
    end
  end

  // Each channel needs one quotient: toward zero below the gray, toward one above.
  logic signed [DIFF_W-1:0] diff [3];
  logic signed [NUM_W-1:0]  n    [3];
  logic [NUM_W-1:0]         un   [3];
  logic [DIFF_W-1:0]        ud   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = DIFF_W'(ch3[i]) - DIFF_W'(lum);
      n[i]    = diff[i][DIFF_W-1] ? NUM_W'(ch3[i]) : NUM_W'(ch3[i]) - NUM_W'(ONE);
      un[i]   = n[i][NUM_W-1] ? NUM_W'(-n[i]) : NUM_W'(n[i]);
      ud[i]   = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.lum <= lum;
      for (int i = 0; i < 3; i++) begin
        side.ch[i]    <= ch3[i];
        side.below[i] <= diff[i][DIFF_W-1];
        side.above[i] <= !diff[i][DIFF_W-1] && (diff[i] != '0);
        side.q_neg[i] <= n[i][NUM_W-1] ^ diff[i][DIFF_W-1];
        dividend[i]   <= {un[i], FRAC_BITS'(0)} + DIV1_NW'(ud[i] >> 1);
        divisor[i]    <= ud[i];
      end
    end
  end

endmodule

### rtl/rgm_mix.sv
// ----------------------------------------------------------------------------
// rgm_mix
// Picks and blends the mix amounts, mixes toward gray and forms the
// operands of the final normalizing division.
// ----------------------------------------------------------------------------
module rgm_mix (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rgm_pkg::REG_W-1:0]         sat_keep,
  input  logic [2:0][rgm_pkg::DIV1_NW-1:0]  quo,
  input  rgm_pkg::side_t                    side,
  output logic [2:0][rgm_pkg::DIV2_NW-1:0]  dividend,
  output logic [rgm_pkg::DIV2_DW-1:0]       divisor
);

  import rgm_pkg::*;

  // Quotients stay below 2^38 at these widths, so the 2^40 limit never bites.
  logic signed [AMT_W-1:0] c1 [3];
  logic signed [CH_W-1:0]  ch1 [3];
  logic signed [LUM_W-1:0] lum1;
  logic [2:0]              below1, above1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c1[i]  <= side.q_neg[i] ? -$signed(AMT_W'(quo[i])) : $signed(AMT_W'(quo[i]));
        ch1[i] <= side.ch[i];
      end
      lum1   <= side.lum;
      below1 <= side.below;
      above1 <= side.above;
    end
  end

  // Running saturation amount after each channel, red first.
  logic signed [AMT_W-1:0] sp [3];
  logic signed [AMT_W-1:0] sat2 [3];
  logic signed [AMT_W-1:0] c2 [3];
  logic signed [CH_W-1:0]  ch2 [3];
  logic signed [LUM_W-1:0] lum2;
  logic [2:0]              above2;

  always_comb begin
    sp[0] = (below1[0] && c1[0] > 0) ? c1[0] : '0;
    sp[1] = (below1[1] && c1[1] > sp[0]) ? c1[1] : sp[0];
    sp[2] = (below1[2] && c1[2] > sp[1]) ? c1[2] : sp[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat2   <= sp;
      c2     <= c1;
      ch2    <= ch1;
      lum2   <= lum1;
      above2 <= above1;
    end
  end

  logic signed [AMT_W-1:0] lc [3];
  logic signed [AMT_W-1:0] lmax;
  logic signed [AMT_W-1:0] sat3, lamt3;
  logic signed [CH_W-1:0]  ch3 [3];
  logic signed [LUM_W-1:0] lum3;

  always_comb begin
    lmax = '0;
    for (int i = 0; i < 3; i++) begin
      lc[i] = above2[i] ? c2[i] : sat2[i];
      if (lc[i] > lmax) begin
        lmax = lc[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat3  <= sat2[2];
      lamt3 <= lmax;
      ch3   <= ch2;
      lum3  <= lum2;
    end
  end

  // The blend product is split in two partial products of the difference.
  logic signed [AMT_W-1:0] dlt;
  logic [40:0]             ppl4;
  logic signed [33:0]      pph4;
  logic signed [AMT_W-1:0] lamt4;
  logic signed [CH_W-1:0]  ch4 [3];
  logic signed [LUM_W-1:0] lum4;

  assign dlt = sat3 - lamt3;

  always_ff @(posedge clk) begin
    if (en) begin
      ppl4  <= sat_keep * dlt[23:0];
      pph4  <= $signed({1'b0, sat_keep}) * $signed(dlt[AMT_W-1:24]);
      lamt4 <= lamt3;
      ch4   <= ch3;
      lum4  <= lum3;
    end
  end

  logic signed [63:0]      bsum;
  logic signed [63:0]      bmix;
  logic [REG_W-1:0]        mix5;
  logic signed [CH_W-1:0]  ch5 [3];
  logic signed [LUM_W-1:0] lum5;

  always_comb begin
    bsum = (64'(pph4) <<< 24) + $signed(64'(ppl4));
    bmix = 64'(lamt4) + rshr(bsum, 16);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (bmix < 0) begin
        mix5 <= '0;
      end else if (bmix > 64'(ONE)) begin
        mix5 <= REG_W'(ONE);
      end else begin
        mix5 <= REG_W'(bmix);
      end
      ch5  <= ch4;
      lum5 <= lum4;
    end
  end

  logic signed [41:0]      p6  [3];
  logic signed [CH_W-1:0]  ch6 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p6[i]  <= $signed({1'b0, mix5}) * (DIFF_W'(lum5) - DIFF_W'(ch5[i]));
        ch6[i] <= ch5[i];
      end
    end
  end

  logic signed [LUM_W-1:0] ch7 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ch7[i] <= LUM_W'(64'(ch6[i]) + rshr(64'(p6[i]), FRAC_BITS));
      end
    end
  end

  logic [DIV2_DW-1:0]      mx;
  logic signed [LUM_W-1:0] ch8 [3];
  logic [DIV2_DW-1:0]      m8;

  always_comb begin
    mx = DIV2_DW'(ONE);
    for (int i = 0; i < 3; i++) begin
      if (ch7[i] > $signed({1'b0, mx})) begin
        mx = DIV2_DW'(ch7[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch8 <= ch7;
      m8  <= mx;
    end
  end

  // A channel at or below zero gets a zero dividend and so a zero quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      divisor <= m8;
      for (int i = 0; i < 3; i++) begin
        if (ch8[i] > 0) begin
          dividend[i] <= {ch8[i][LUM_W-1:0], FRAC_BITS'(0)} + DIV2_NW'(m8 >> 1);
        end else begin
          dividend[i] <= '0;
        end
      end
    end
  end

endmodule

### rtl/rec2020_to_709_gamut_map.sv
// ----------------------------------------------------------------------------
// rec2020_to_709_gamut_map
// Maps linear Rec.2020 pixels into the Rec.709 gamut by mixing toward gray.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         in_red, in_green, in_blue (Q2.16)
// m_axis    out        out_red, out_green, out_blue (Q1.16)
// cfg       in         cfg_index, cfg_data (weights and blend factor)
//
// One pixel is taken per clock while the pipeline is not halted; the two
// restoring dividers work out one quotient bit a stage.
// Reset clears the valid line and the output buffer and reloads the registers.
// A two-entry output buffer absorbs stalls; the pipeline halts only when the
// buffer is full and the last stage holds a pixel.
// Register writes are taken only while no pixel is inside the pipeline.
// ----------------------------------------------------------------------------
module rec2020_to_709_gamut_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // in_red [17:0], in_green [35:18], in_blue [53:36], zeros above
  input  logic [rgm_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_red [16:0], out_green [33:17], out_blue [50:34], zeros above
  output logic [rgm_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgm_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rgm_pkg::REG_W-1:0]         cfg_data
);

  import rgm_pkg::*;

  localparam int FRONT_LAT = 5;
  localparam int MIX_LAT   = 9;
  localparam int LAT       = FRONT_LAT + DIV1_NW + MIX_LAT + DIV2_QW;

  logic [REG_W-1:0] luma_red, luma_green, luma_blue, sat_keep;

  logic [LAT-1:0] vld;
  logic           en;
  logic [1:0]     count;
  logic           full;

  assign cfg_ready = !rst && (vld == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_red   <= REG_W'(13933);
      luma_green <= REG_W'(46871);
      luma_blue  <= REG_W'(4732);
      sat_keep   <= REG_W'(26214);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_LUMA_RED:   luma_red   <= cfg_data;
        REG_LUMA_GREEN: luma_green <= cfg_data;
        REG_LUMA_BLUE:  luma_blue  <= cfg_data;
        REG_SAT_KEEP:   sat_keep   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full          = (count == 2'd2);
  assign en            = !(vld[LAT-1] && full);
  assign s_axis_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  side_t                   side_f, side_d;
  logic [2:0][DIV1_NW-1:0] num1;
  logic [2:0][DIV1_DW-1:0] den1;
  logic [2:0][DIV1_NW-1:0] quo1;
  logic [2:0][DIV2_NW-1:0] num2;
  logic [DIV2_DW-1:0]      den2;
  logic [2:0][DIV2_QW-1:0] quo2;

  rgm_front u_front (
    .clk      (clk),
    .en       (en),
    .in_red   (s_axis_tdata[IN_W-1:0]),
    .in_green (s_axis_tdata[2*IN_W-1:IN_W]),
    .in_blue  (s_axis_tdata[3*IN_W-1:2*IN_W]),
    .w_red    (luma_red),
    .w_green  (luma_green),
    .w_blue   (luma_blue),
    .side     (side_f),
    .dividend (num1),
    .divisor  (den1)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rgm_div #(.NW(DIV1_NW), .DW(DIV1_DW), .QW(DIV1_NW)) u_amt_div (
      .clk (clk),
      .en  (en),
      .num (num1[i]),
      .den (den1[i]),
      .quo (quo1[i])
    );

    rgm_div #(.NW(DIV2_NW), .DW(DIV2_DW), .QW(DIV2_QW)) u_norm_div (
      .clk (clk),
      .en  (en),
      .num (num2[i]),
      .den (den2),
      .quo (quo2[i])
    );
  end

  rgm_dly #(.W($bits(side_t)), .N(DIV1_NW)) u_side_dly (
    .clk (clk),
    .en  (en),
    .d   (side_f),
    .q   (side_d)
  );

  rgm_mix u_mix (
    .clk      (clk),
    .en       (en),
    .sat_keep (sat_keep),
    .quo      (quo1),
    .side     (side_d),
    .dividend (num2),
    .divisor  (den2)
  );

  // Two-entry output buffer.
  logic [TDATA_OUT_W-1:0] buf_data [2];
  logic                   wr_ptr, rd_ptr;
  logic                   push, pop;

  assign push = en && vld[LAT-1];
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_data[wr_ptr] <= {(TDATA_OUT_W - 3*OUT_W)'(0), quo2[2], quo2[1], quo2[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = buf_data[rd_ptr];

endmodule

### rtl/rgm_checker.sv
// ----------------------------------------------------------------------------
// rgm_checker
// Port-level checks of the gamut mapper, bound to the top level.
// ----------------------------------------------------------------------------
module rgm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rgm_pkg::TDATA_OUT_W-1:0]   m_axis_tdata
);

  import rgm_pkg::*;

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'd65536) &&
                      (m_axis_tdata[33:17] <= 17'd65536) &&
                      (m_axis_tdata[50:34] <= 17'd65536))
    else $error("output component above one");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[TDATA_OUT_W-1:3*OUT_W] == '0))
    else $error("output padding bits not zero");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind rec2020_to_709_gamut_map rgm_checker u_rgm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Rec.2020 to Rec.709 gamut mapper. Pixels are
// streamed in under random gaps and output back-pressure. Each result is
// compared with a bit-exact software mapper kept in step with the register
// settings, which are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import rgm_pkg::*;

  localparam int LATENCY   = 69;
  localparam int IDLE_WAIT = LATENCY + 20;
  localparam int WDOG_MAX  = 5000;
  localparam int N_RANDOM  = 1230;
  localparam int N_DIRECT  = 16;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } pixel_out_t;

  typedef struct packed {
    bit            known;
    bit [IN_W-1:0] red;
    bit [IN_W-1:0] green;
    bit [IN_W-1:0] blue;
    pixel_out_t    res;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index;
  logic [REG_W-1:0]       cfg_data;

  rec2020_to_709_gamut_map DUT (.*);

  // Mirror of the block's registers.
  longint wgt_red, wgt_green, wgt_blue, sat_blend;
  longint mat_coef [9];

  pixel_out_t mapped_q[$];
  int         errors;
  int         pixels_sent;
  int         pixels_seen;
  int         cfg_writes;
  int         idle_cycles;
  stim_row_t  dir_rows [N_DIRECT];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint round_shift(longint x, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (x >= 0) return (x + half) >>> s;
    return -((-x + half) >>> s);
  endfunction

  // Quotient n * 2^16 / d rounded, magnitude held at 2^40.
  function automatic longint mix_ratio(longint n, longint d);
    longint un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = ((un << FRAC_BITS) + ud / 2) / ud;
    if (q > (longint'(1) << 40)) q = longint'(1) << 40;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic pixel_out_t map_pixel(bit [IN_W-1:0] r, bit [IN_W-1:0] g,
                                           bit [IN_W-1:0] b);
    longint src [3];
    longint ch [3];
    longint acc, lum, diff, cand, sat_amt, lum_amt, mix, peak, o;
    longint res [3];
    pixel_out_t po;
    src[0] = longint'(r); src[1] = longint'(g); src[2] = longint'(b);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += mat_coef[i*3+j] * src[j];
      ch[i] = round_shift(acc, COEF_FRAC_BITS);
    end
    lum = round_shift(wgt_red * ch[0] + wgt_green * ch[1] + wgt_blue * ch[2], 16);
    sat_amt = 0;
    lum_amt = 0;
    for (int i = 0; i < 3; i++) begin
      diff = ch[i] - lum;
      if (diff < 0) begin
        cand = mix_ratio(ch[i], diff);
        if (cand > sat_amt) sat_amt = cand;
      end
      if (diff <= 0) cand = sat_amt;
      else cand = mix_ratio(ch[i] - (longint'(1) << FRAC_BITS), diff);
      if (cand > lum_amt) lum_amt = cand;
    end
    mix = lum_amt + round_shift(sat_blend * (sat_amt - lum_amt), 16);
    if (mix < 0) mix = 0;
    if (mix > (longint'(1) << FRAC_BITS)) mix = longint'(1) << FRAC_BITS;
    peak = longint'(1) << FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      ch[i] = ch[i] + round_shift(mix * (lum - ch[i]), FRAC_BITS);
      if (ch[i] > peak) peak = ch[i];
    end
    for (int i = 0; i < 3; i++) begin
      if (ch[i] <= 0) o = 0;
      else begin
        o = ((ch[i] << 16) + peak / 2) / peak;
        if (o > 65536) o = 65536;
      end
      res[i] = o;
    end
    po.red   = res[0][OUT_W-1:0];
    po.green = res[1][OUT_W-1:0];
    po.blue  = res[2][OUT_W-1:0];
    return po;
  endfunction

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(reg_idx_t idx, bit [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      REG_LUMA_RED:   wgt_red   = longint'(val);
      REG_LUMA_GREEN: wgt_green = longint'(val);
      REG_LUMA_BLUE:  wgt_blue  = longint'(val);
      REG_SAT_KEEP:   sat_blend = longint'(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (mapped_q.size() == 0);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic apply_setting(bit [REG_W-1:0] wr, bit [REG_W-1:0] wg,
                               bit [REG_W-1:0] wb, bit [REG_W-1:0] k);
    drain();
    write_reg(REG_LUMA_RED, wr);
    write_reg(REG_LUMA_GREEN, wg);
    write_reg(REG_LUMA_BLUE, wb);
    write_reg(REG_SAT_KEEP, k);
    cfg_valid <= 1'b0;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_pixel(bit [IN_W-1:0] r, bit [IN_W-1:0] g, bit [IN_W-1:0] b,
                            bit known, pixel_out_t res);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, b, g, r};
    do @(posedge clk); while (!s_axis_tready);
    mapped_q.push_back(known ? res : map_pixel(r, g, b));
    pixels_sent++;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random pixel: most often plausible colors, some full-range noise, some
  // nearly gray pixels that push the mix amounts to their limit, and some pixels with each channel near zero or high.
  task automatic send_random();
    bit [IN_W-1:0] r, g, b;
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) begin
      r = IN_W'($urandom_range(0, 65536));
      g = IN_W'($urandom_range(0, 65536));
      b = IN_W'($urandom_range(0, 65536));
    end else if (p < 70) begin
      r = IN_W'($urandom());
      g = IN_W'($urandom());
      b = IN_W'($urandom());
    end else if (p < 85) begin
      r = IN_W'($urandom_range(0, 262143));
      g = IN_W'(r + $urandom_range(0, 6) - 3);
      b = IN_W'(r + $urandom_range(0, 6) - 3);
    end else begin
      r = IN_W'(($urandom_range(0, 1)) ? $urandom_range(0, 300)
                                       : $urandom_range(100000, 262143));
      g = IN_W'(($urandom_range(0, 1)) ? $urandom_range(0, 300)
                                       : $urandom_range(100000, 262143));
      b = IN_W'(($urandom_range(0, 1)) ? $urandom_range(0, 300)
                                       : $urandom_range(100000, 262143));
    end
    send_pixel(r, g, b, 1'b0, '0);
  endtask

  // Receiver back-pressure.
  initial begin
    int p;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      p = $urandom_range(0, 99);
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (p < 90) begin
        m_axis_tready <= 1'b0;
        repeat ((p < 80) ? $urandom_range(1, 4) : $urandom_range(30, 200)) @(posedge clk);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    pixel_out_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.red   = m_axis_tdata[16:0];
      got.green = m_axis_tdata[33:17];
      got.blue  = m_axis_tdata[50:34];
      pixels_seen++;
      if (mapped_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        want = mapped_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: pixel %0d exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     pixels_seen, want.red, want.green, want.blue,
                     got.red, got.green, got.blue);
        end
      end
    end
  end

  // Watchdog on cycles with no request accepted anywhere.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired with %0d results outstanding", mapped_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int c10000 [9];
    longint mag;
    c10000 = '{16605, -5876, -728, -1246, 11329, -84, -181, -1006, 11187};
    for (int i = 0; i < 9; i++) begin
      mag = longint'((c10000[i] < 0) ? -c10000[i] : c10000[i]);
      mag = ((mag << COEF_FRAC_BITS) + 5000) / 10000;
      mat_coef[i] = (c10000[i] < 0) ? -mag : mag;
    end
    wgt_red = 13933; wgt_green = 46871; wgt_blue = 4732; sat_blend = 26214;
    errors = 0; pixels_sent = 0; pixels_seen = 0; cfg_writes = 0;
    idle_cycles = 0;
    dir_rows = '{
      '{1'b1, 18'd0,      18'd0,      18'd0,      '0},
      '{1'b0, 18'd262143, 18'd262143, 18'd262143, '0},
      '{1'b0, 18'd262143, 18'd0,      18'd0,      '0},
      '{1'b0, 18'd0,      18'd262143, 18'd0,      '0},
      '{1'b0, 18'd0,      18'd0,      18'd262143, '0},
      '{1'b0, 18'd65536,  18'd65536,  18'd65536,  '0},
      '{1'b0, 18'd65536,  18'd0,      18'd0,      '0},
      '{1'b0, 18'd0,      18'd65536,  18'd0,      '0},
      '{1'b0, 18'd0,      18'd0,      18'd65536,  '0},
      '{1'b0, 18'd65536,  18'd65537,  18'd65536,  '0},
      '{1'b0, 18'd1,      18'd0,      18'd0,      '0},
      '{1'b0, 18'd0,      18'd1,      18'd1,      '0},
      '{1'b0, 18'd131072, 18'd65536,  18'd32768,  '0},
      '{1'b0, 18'd200000, 18'd10,     18'd150000, '0},
      '{1'b0, 18'd21845,  18'd174762, 18'd87381,  '0},
      '{1'b0, 18'd262143, 18'd131071, 18'd1,      '0}
    };
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_LUMA_RED;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_pixel(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                 dir_rows[i].known, dir_rows[i].res);
    // Extreme settings, then random settings, then back to the reset values.
    apply_setting(17'd0, 17'd0, 17'd0, 17'd0);
    foreach (dir_rows[i]) send_pixel(dir_rows[i].red, dir_rows[i].green,
                                     dir_rows[i].blue, 1'b0, '0);
    apply_setting(17'd65536, 17'd65536, 17'd65536, 17'd65536);
    foreach (dir_rows[i]) send_pixel(dir_rows[i].red, dir_rows[i].green,
                                     dir_rows[i].blue, 1'b0, '0);
    apply_setting(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    repeat (40) send_random();
    for (int ph = 0; ph < 6; ph++) begin
      apply_setting(REG_W'($urandom_range(0, 65536)), REG_W'($urandom_range(0, 65536)),
                    REG_W'($urandom_range(0, 65536)), REG_W'($urandom_range(0, 65536)));
      repeat (N_RANDOM / 8) send_random();
    end
    apply_setting(17'd13933, 17'd46871, 17'd4732, 17'd26214);
    repeat (N_RANDOM / 4) send_random();
    s_axis_tvalid <= 1'b0;

    wait (mapped_q.size() == 0);
    repeat (IDLE_WAIT) @(posedge clk);
    $display("Mapped %0d pixels through %0d register writes, %0d results checked.",
             pixels_sent, cfg_writes, pixels_seen);
    if (errors == 0 && mapped_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, mapped_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rgm_pkg.sv
rtl/rgm_dly.sv
rtl/rgm_div.sv
rtl/rgm_front.sv
rtl/rgm_mix.sv
rtl/rec2020_to_709_gamut_map.sv
rtl/rgm_checker.sv
tb/tb_top.sv
